FILE: rtl/congestion_window_controller_unit_assert.svh
// assertion macros for the congestion window controller
`ifndef CONGESTION_WINDOW_CONTROLLER_UNIT_ASSERT_SVH
`define CONGESTION_WINDOW_CONTROLLER_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define CWC_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define CWC_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

FILE: rtl/cwc_pkg.sv
// shared types and constants of the congestion window controller
`default_nettype none
package cwc_pkg;
   localparam int unsigned SegmentBytes = 1024;
   localparam int unsigned SegShift = $clog2(SegmentBytes);
   localparam logic [15:0] WinMax = 16'hFFFF;
   localparam logic [30:0] NextMax = 31'h7FFF_FFFF;
   localparam logic [7:0] DupMax = 8'd255;
   localparam logic [7:0] DupFast = 8'd3;

   typedef enum logic [1:0] {
      OP_ACK = 2'd0,
      OP_TIMEOUT = 2'd1,
      OP_SENT = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_INIT_CWND = 3'd0,
      CSR_INIT_SSTHRESH = 3'd1,
      CSR_INIT_SWND = 3'd2,
      CSR_INIT_RWND = 3'd3,
      CSR_MAX_SWND = 3'd4
   } csr_type;

   // classified event handed from front to back
   typedef struct packed {
      op_type op;
      logic [30:0] ack;
      logic [15:0] peer;
   } evt_type;
endpackage
`default_nettype wire

FILE: rtl/cwc_front.sv
// input stage and two-entry event queue
`default_nettype none
module cwc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire cwc_pkg::evt_type req_evt,
   output logic evt_valid,
   input wire logic evt_ready,
   output cwc_pkg::evt_type evt_data
);
   import cwc_pkg::*;

   evt_type q_ff [2];
   evt_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_en, rd_en;

   assign req_ready = (cnt_ff != 2'd2);
   assign evt_valid = (cnt_ff != 2'd0);
   assign evt_data = q_ff[0];
   assign wr_en = req_valid && req_ready;
   assign rd_en = evt_valid && evt_ready;

   // shift queue update
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      if (rd_en) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (wr_en) begin
         if (cnt_in == 2'd0) q_in[0] = req_evt;
         else q_in[1] = req_evt;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

`include "congestion_window_controller_unit_assert.svh"
   `CWC_ASSERT_IMP(a_cnt_max, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `CWC_ASSERT_NXT(a_full_stays, clock, reset, cnt_ff == 2'd2 && !rd_en, cnt_ff == 2'd2)
   `CWC_ASSERT_NXT(a_empty_fill, clock, reset, cnt_ff == 2'd0 && wr_en, evt_valid)
endmodule
`default_nettype wire

FILE: rtl/cwc_divider.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module cwc_divider (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [31:0] dividend,
   input wire logic [15:0] divisor,
   output logic busy,
   output logic done,
   output logic [31:0] quotient,
   output logic [15:0] remainder
);
   import cwc_pkg::*;

   logic [31:0] q_ff;
   logic [16:0] r_ff;
   logic [15:0] d_ff;
   logic [5:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [16:0] trial;
   logic [16:0] shifted;

   assign shifted = {r_ff[15:0], q_ff[31]};
   assign trial = shifted - {1'b0, d_ff};
   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff[15:0];

   // one shift and subtract step a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff <= dividend;
         r_ff <= 17'd0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            r_ff <= trial;
            q_ff <= {q_ff[30:0], 1'b1};
         end else begin
            r_ff <= shifted;
            q_ff <= {q_ff[30:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/cwc_back.sv
// window state update and result register
`default_nettype none
module cwc_back (
   input wire logic clock,
   input wire logic reset,
   input wire logic evt_valid,
   output logic evt_ready,
   input wire cwc_pkg::evt_type evt_data,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [15:0] rsp_send_window,
   output logic [15:0] rsp_congestion_window,
   output logic [15:0] rsp_threshold,
   output logic [31:0] rsp_base_index,
   output logic [30:0] rsp_next_index,
   output logic [30:0] rsp_released_count,
   output logic rsp_go_back,
   output logic rsp_skip_timer,
   output logic rsp_ignored,
   output logic rsp_send_permit
);
   import cwc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV = 4'b0010,
      ST_FIN = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [15:0] cwnd_ff, ssth_ff, swnd_ff, rwnd_ff, maxw_ff;
   logic [15:0] icwnd_ff, issth_ff, iswnd_ff, irwnd_ff;
   logic [31:0] credit_ff;
   logic [31:0] last_ff;
   logic [7:0] dup_ff;
   logic [31:0] base_ff;
   logic [31:0] next_ff;
   logic skip_ff;
   logic [30:0] rel_ff;
   logic gb_ff, ign_ff;
   op_type op_ff;

   logic div_start, div_busy, div_done;
   logic [31:0] div_q;
   logic [15:0] div_r;
   logic [15:0] divisor;

   // combinational helpers
   logic [31:0] ack32, seg, cred_sum, rel_s;
   logic [15:0] half_cwnd, new_cwnd, min_cr;
   logic [16:0] sum17;
   logic [32:0] diff;
   logic permit;
   logic [7:0] dup_n;
   logic is_dup, is_newer;

   cwc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(cred_sum),
      .divisor(divisor), .busy(div_busy), .done(div_done), .quotient(div_q),
      .remainder(div_r)
   );

   assign divisor = (cwnd_ff == 16'd0) ? 16'd1 : cwnd_ff;
   assign ack32 = {1'b0, evt_data.ack};
   assign seg = {{(SegShift + 1){1'b0}}, evt_data.ack[30:SegShift]};
   assign cred_sum = credit_ff + (ack32 - last_ff);
   assign rel_s = seg - base_ff - 32'd1;
   assign half_cwnd = (cwnd_ff[15:1] == 15'd0) ? 16'd1 : {1'b0, cwnd_ff[15:1]};
   assign sum17 = {1'b0, cwnd_ff} + {1'b0, div_q[15:0]};
   assign new_cwnd = (sum17[16] || div_q[31:16] != 16'd0) ? WinMax : sum17[15:0];
   assign diff = {next_ff[31], next_ff} - {base_ff[31], base_ff};
   assign permit = $signed(diff) <= $signed({17'd0, swnd_ff});
   assign dup_n = (dup_ff < DupMax) ? dup_ff + 8'd1 : dup_ff;
   assign is_dup = (last_ff == ack32);
   assign is_newer = $signed(ack32) > $signed(last_ff);
   assign evt_ready = (st_ff == ST_IDLE);
   assign div_start = (st_ff == ST_IDLE) && evt_valid && evt_data.op == OP_ACK
      && is_newer && !(cwnd_ff < ssth_ff)
      && cred_sum >= {16'd0, divisor};

   function automatic logic [15:0] min3(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c);
      logic [15:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   assign min_cr = min3(cwnd_ff, rwnd_ff, maxw_ff);

   // sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (evt_valid) st_in = div_start ? ST_DIV : ST_FIN;
         ST_DIV: if (div_done) st_in = ST_FIN;
         ST_FIN: st_in = ST_OUT;
         ST_OUT: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         icwnd_ff <= 16'd1; issth_ff <= 16'd64; iswnd_ff <= 16'd1;
         irwnd_ff <= 16'd64; maxw_ff <= 16'd64;
         cwnd_ff <= 16'd1; ssth_ff <= 16'd64; swnd_ff <= 16'd1; rwnd_ff <= 16'd64;
         credit_ff <= 32'd0; last_ff <= 32'hFFFF_FFFF; dup_ff <= 8'd0;
         base_ff <= 32'hFFFF_FFFF; next_ff <= 32'd0; skip_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         // configuration writes
         if (csr_write) begin
            case (csr_index)
               CSR_INIT_CWND: begin icwnd_ff <= csr_data; cwnd_ff <= csr_data; end
               CSR_INIT_SSTHRESH: begin issth_ff <= csr_data; ssth_ff <= csr_data; end
               CSR_INIT_SWND: begin iswnd_ff <= csr_data; swnd_ff <= csr_data; end
               CSR_INIT_RWND: begin irwnd_ff <= csr_data; rwnd_ff <= csr_data; end
               CSR_MAX_SWND: maxw_ff <= csr_data;
               default: ;
            endcase
         end
         // event execution
         if (st_ff == ST_IDLE && evt_valid) begin
            op_ff <= evt_data.op;
            gb_ff <= (evt_data.op == OP_TIMEOUT)
               || (evt_data.op == OP_ACK && is_dup && dup_n == DupFast);
            ign_ff <= (evt_data.op == OP_ACK) && $signed(last_ff) > $signed(ack32);
            rel_ff <= (evt_data.op == OP_ACK && is_newer && $signed(rel_s) > 0)
               ? rel_s[30:0] : 31'd0;
            case (evt_data.op)
               OP_ACK: begin
                  if (is_dup) begin
                     dup_ff <= dup_n;
                     if (dup_n == DupFast) begin
                        ssth_ff <= half_cwnd;
                        cwnd_ff <= ssth_ff;
                        next_ff <= base_ff + 32'd1;
                        skip_ff <= 1'b1;
                     end
                     last_ff <= ack32;
                  end else if (is_newer) begin
                     dup_ff <= 8'd0;
                     rwnd_ff <= evt_data.peer;
                     if (cwnd_ff < ssth_ff) cwnd_ff <= cwnd_ff + 16'd1;
                     else credit_ff <= cred_sum;
                     base_ff <= seg - 32'd1;
                     if ($signed(next_ff) < $signed(seg)) next_ff <= seg;
                     last_ff <= ack32;
                  end
               end
               OP_TIMEOUT: begin
                  ssth_ff <= half_cwnd;
                  cwnd_ff <= 16'd1;
                  next_ff <= base_ff + 32'd1;
               end
               OP_SENT: begin
                  if (permit) begin
                     if (next_ff[30:0] != NextMax || next_ff[31]) next_ff <= next_ff + 32'd1;
                  end else skip_ff <= 1'b0;
               end
               default: ;
            endcase
         end
         if (div_done) begin
            credit_ff <= {16'd0, div_r};
            cwnd_ff <= new_cwnd;
         end
         // recompute send window for window-changing events
         if (st_ff == ST_FIN && (gb_ff || (op_ff == OP_ACK && !ign_ff
             && (rel_ff != 31'd0 || dup_ff == 8'd0))))
            swnd_ff <= min_cr;
      end
   end

   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_send_window = swnd_ff;
   assign rsp_congestion_window = cwnd_ff;
   assign rsp_threshold = ssth_ff;
   assign rsp_base_index = base_ff;
   assign rsp_next_index = next_ff[30:0];
   assign rsp_released_count = rel_ff;
   assign rsp_go_back = gb_ff;
   assign rsp_skip_timer = skip_ff;
   assign rsp_ignored = ign_ff;
   assign rsp_send_permit = permit;

   // stored init values are not read back
   logic unused_init;
   assign unused_init = ^{icwnd_ff, issth_ff, iswnd_ff, irwnd_ff, div_busy};

`include "congestion_window_controller_unit_assert.svh"
   `CWC_ASSERT_IMP(a_div_idle, clock, reset, div_start, st_ff == ST_IDLE)
   `CWC_ASSERT_IMP(a_out_onehot, clock, reset, 1'b1, $onehot(st_ff))
   `CWC_ASSERT_NXT(a_div_done_fin, clock, reset, div_done, st_ff == ST_FIN)
endmodule
`default_nettype wire

FILE: rtl/congestion_window_controller_unit.sv
// top level of the congestion window controller
// path: front queue, then back end states IDLE, FIN, OUT; DIV before FIN when congestion avoidance divides
// the back end takes a new item only after the last result is taken; DIV runs the serial 32-step credit divider
// a two-entry queue in front takes items while the back end works
// reset: synchronous, active high; control and window registers return to defaults, queue entries are not reset
`default_nettype none
module congestion_window_controller_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   input wire logic [30:0] req_ack_bytes,
   input wire logic [15:0] req_peer_window,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [15:0] rsp_send_window,
   output logic [15:0] rsp_congestion_window,
   output logic [15:0] rsp_threshold,
   output logic [31:0] rsp_base_index,
   output logic [30:0] rsp_next_index,
   output logic [30:0] rsp_released_count,
   output logic rsp_go_back,
   output logic rsp_skip_timer,
   output logic rsp_ignored,
   output logic rsp_send_permit,
   input wire logic csr_write,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_data
);
   import cwc_pkg::*;

   evt_type req_evt, evt_data;
   logic evt_valid, evt_ready;

   assign req_evt.op = op_type'(req_operation);
   assign req_evt.ack = req_ack_bytes;
   assign req_evt.peer = req_peer_window;

   cwc_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_evt(req_evt), .evt_valid(evt_valid), .evt_ready(evt_ready),
      .evt_data(evt_data)
   );

   cwc_back u_back (
      .clock(clock), .reset(reset), .evt_valid(evt_valid), .evt_ready(evt_ready),
      .evt_data(evt_data), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_send_window(rsp_send_window), .rsp_congestion_window(rsp_congestion_window),
      .rsp_threshold(rsp_threshold), .rsp_base_index(rsp_base_index),
      .rsp_next_index(rsp_next_index), .rsp_released_count(rsp_released_count),
      .rsp_go_back(rsp_go_back), .rsp_skip_timer(rsp_skip_timer),
      .rsp_ignored(rsp_ignored), .rsp_send_permit(rsp_send_permit)
   );
endmodule
`default_nettype wire
